// File: rtl/iba_pkg.sv
// Package for the inode block allocator: status codes, operation kinds and
// payload structs. No dependencies.
package iba_pkg;

  localparam int NameW   = 64;
  localparam int KindW   = 2;
  localparam int CountW  = 4;
  localparam int IndexW  = 3;
  localparam int StatusW = 3;
  localparam int PhysW   = 7;
  localparam int FreeW   = 7;

  localparam logic [KindW-1:0] KIND_CREATE    = 2'd0;
  localparam logic [KindW-1:0] KIND_DELETE    = 2'd1;
  localparam logic [KindW-1:0] KIND_TRANSLATE = 2'd2;
  localparam logic [KindW-1:0] KIND_NOP       = 2'd3;

  localparam logic [StatusW-1:0] ST_OK        = 3'd0;
  localparam logic [StatusW-1:0] ST_NO_SPACE  = 3'd1;
  localparam logic [StatusW-1:0] ST_DUPLICATE = 3'd2;
  localparam logic [StatusW-1:0] ST_NO_SLOT   = 3'd3;
  localparam logic [StatusW-1:0] ST_NOT_FOUND = 3'd4;
  localparam logic [StatusW-1:0] ST_RANGE     = 3'd5;
  localparam logic [StatusW-1:0] ST_BAD_SIZE  = 3'd6;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [NameW-1:0]  file_name;
    logic [CountW-1:0] block_count;
    logic [IndexW-1:0] block_index;
  } req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [PhysW-1:0]   phys_block;
    logic [FreeW-1:0]   free_count;
  } rsp_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_req;     // capture request
    logic search_start; // clear search state
    logic search_step;  // examine one slot
    logic create_init;  // claim slot, write name and size
    logic alloc_step;   // examine one bitmap block
    logic map_read;     // issue block map read for current index
    logic free_step;    // release block returned by map read
    logic delete_fin;   // release slot
    logic xlate_fin;    // latch translate result
    logic set_status;   // load status register
    logic [StatusW-1:0] status;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic search_done;
    logic found;
    logic have_free;
    logic bad_size;
    logic no_space;
    logic alloc_done;
    logic free_done;
    logic idx_bad;
  } sts_t;

endpackage

// File: rtl/iba_if.sv
// Valid/ready channel interface carrying a typed payload.
// Depends on iba_pkg only through the payload type parameter given by users.
interface iba_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/iba_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module iba_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// File: rtl/iba_datapath.sv
// Datapath: slot table, free-block bitmap, block map memory and counters.
// Depends on iba_pkg and iba_ram.
module iba_datapath #(
  parameter int NumSlots = 16,
  parameter int NumBlocks = 128,
  parameter int BlocksPerFile = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  iba_pkg::req_t req,
  input  iba_pkg::cmd_t cmd,
  output iba_pkg::sts_t sts,
  output iba_pkg::rsp_t rsp
);
  import iba_pkg::*;

  localparam int SlotW = $clog2(NumSlots);
  localparam int BlkW  = $clog2(NumBlocks);
  localparam int SizeW = $clog2(BlocksPerFile + 1);
  localparam int CntW  = $clog2(NumBlocks);
  localparam int SCntW = $clog2(NumSlots + 1);
  localparam int MapD  = NumSlots * BlocksPerFile;
  localparam int MapAW = $clog2(MapD);

  req_t                 req_r;
  logic [NumSlots-1:0]  used_r;
  logic [NameW-1:0]     name_r [NumSlots];
  logic [SizeW-1:0]     size_r [NumSlots];
  logic [NumBlocks-1:0] taken_r;
  logic [CntW-1:0]      free_r;
  logic [SCntW-1:0]     scan_r;
  logic                 found_r;
  logic                 have_free_r;
  logic [SlotW-1:0]     hit_r;
  logic [SlotW-1:0]     free_slot_r;
  logic [BlkW:0]        blk_r;
  logic [SizeW-1:0]     j_r;
  logic [StatusW-1:0]   status_r;
  logic [PhysW-1:0]     phys_r;

  logic                 map_we;
  logic [MapAW-1:0]     map_addr;
  logic [BlkW-1:0]      map_rdata;
  logic [SlotW-1:0]     cur_slot;
  logic [SlotW-1:0]     scan_idx;
  logic [SizeW-1:0]     cur_size;
  logic [BlkW-1:0]      blk_idx;

  assign scan_idx = scan_r[SlotW-1:0];
  assign cur_slot = found_r ? hit_r : free_slot_r;
  assign cur_size = size_r[hit_r];
  assign blk_idx  = blk_r[BlkW-1:0];

  always_comb begin
    map_we = cmd.alloc_step && !taken_r[blk_idx] && (j_r < SizeW'(req_r.block_count));
    if (req_r.kind == KIND_TRANSLATE)
      map_addr = MapAW'(hit_r) * MapAW'(BlocksPerFile) + MapAW'(req_r.block_index);
    else
      map_addr = MapAW'(cur_slot) * MapAW'(BlocksPerFile) + MapAW'(j_r);
  end

  iba_ram #(.Width(BlkW), .Depth(MapD)) u_map (
    .clk(clk), .we(map_we), .addr(map_addr), .wdata(blk_idx), .rdata(map_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r   <= '0;
      taken_r  <= NumBlocks'(1);
      free_r   <= CntW'(NumBlocks - 1);
      scan_r   <= '0;
      found_r  <= 1'b0;
      have_free_r <= 1'b0;
      blk_r    <= '0;
      j_r      <= '0;
      status_r <= ST_OK;
      phys_r   <= '0;
      for (int i = 0; i < NumSlots; i++) size_r[i] <= '0;
    end else begin
      if (cmd.load_req) req_r <= req;
      if (cmd.search_start) begin
        scan_r <= '0;
        found_r <= 1'b0;
        have_free_r <= 1'b0;
        phys_r <= '0;
      end
      if (cmd.search_step) begin
        if (used_r[scan_idx] && name_r[scan_idx] == req_r.file_name && !found_r) begin
          found_r <= 1'b1;
          hit_r <= scan_idx;
        end
        if (!used_r[scan_idx] && !have_free_r) begin
          have_free_r <= 1'b1;
          free_slot_r <= scan_idx;
        end
        scan_r <= scan_r + 1'b1;
      end
      if (cmd.create_init) begin
        used_r[free_slot_r] <= 1'b1;
        name_r[free_slot_r] <= req_r.file_name;
        size_r[free_slot_r] <= SizeW'(req_r.block_count);
        found_r <= 1'b0;
        blk_r <= (BlkW+1)'(1);
        j_r <= '0;
      end
      if (cmd.alloc_step) begin
        if (map_we) begin
          taken_r[blk_idx] <= 1'b1;
          j_r <= j_r + 1'b1;
          free_r <= free_r - 1'b1;
        end
        blk_r <= blk_r + 1'b1;
      end
      if (cmd.map_read && req_r.kind == KIND_DELETE && !cmd.free_step) j_r <= '0;
      if (cmd.free_step) begin
        if (taken_r[map_rdata]) begin
          taken_r[map_rdata] <= 1'b0;
          free_r <= free_r + 1'b1;
        end
        j_r <= j_r + 1'b1;
      end
      if (cmd.delete_fin) begin
        used_r[hit_r] <= 1'b0;
        size_r[hit_r] <= '0;
      end
      if (cmd.xlate_fin) phys_r <= PhysW'(map_rdata);
      if (cmd.set_status) status_r <= cmd.status;
    end
  end

  always_comb begin
    sts.kind        = req_r.kind;
    sts.search_done = (scan_r == SCntW'(NumSlots));
    sts.found       = found_r;
    sts.have_free   = have_free_r;
    sts.bad_size    = {1'b0, req_r.block_count} > (CountW+1)'(BlocksPerFile);
    sts.no_space    = (CntW+1)'(free_r) < (CntW+1)'(req_r.block_count);
    sts.alloc_done  = (j_r == SizeW'(req_r.block_count)) || (blk_r == (BlkW+1)'(NumBlocks));
    sts.free_done   = (j_r >= cur_size) || (j_r >= SizeW'(BlocksPerFile));
    sts.idx_bad     = ((SizeW+IndexW)'(req_r.block_index) >= (SizeW+IndexW)'(cur_size))
                      || ((IndexW+SizeW)'(req_r.block_index) >= (IndexW+SizeW)'(BlocksPerFile));
    rsp.status      = status_r;
    rsp.phys_block  = phys_r;
    rsp.free_count  = FreeW'(free_r);
  end
endmodule

// File: rtl/iba_ctrl.sv
// Controller state machine sequencing search, allocate, free and translate.
// Depends on iba_pkg.
module iba_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  iba_pkg::sts_t sts,
  output iba_pkg::cmd_t cmd
);
  import iba_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SEARCH = 4'd1;
  localparam logic [3:0] S_DECIDE = 4'd2;
  localparam logic [3:0] S_ALLOC  = 4'd3;
  localparam logic [3:0] S_FREE_A = 4'd4;
  localparam logic [3:0] S_FREE_B = 4'd5;
  localparam logic [3:0] S_XLATE  = 4'd6;
  localparam logic [3:0] S_XWAIT  = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       in_acc;

  assign in_ready  = (state_r == S_IDLE) || (state_r == S_OUT && out_ready);
  assign out_valid = (state_r == S_OUT);
  assign in_acc    = in_valid && in_ready;

  always_comb begin
    cmd = '0;
    cmd.status = ST_OK;
    state_nxt = state_r;
    if (in_acc) begin
      cmd.load_req = 1'b1;
      cmd.search_start = 1'b1;
    end
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_SEARCH;
      S_OUT: begin
        if (in_acc) state_nxt = S_SEARCH;
        else if (out_ready) state_nxt = S_IDLE;
      end
      S_SEARCH: begin
        if (sts.search_done) state_nxt = S_DECIDE;
        else cmd.search_step = 1'b1;
      end
      S_DECIDE: begin
        cmd.set_status = 1'b1;
        state_nxt = S_OUT;
        unique case (sts.kind)
          KIND_CREATE: begin
            if (sts.bad_size) cmd.status = ST_BAD_SIZE;
            else if (sts.no_space) cmd.status = ST_NO_SPACE;
            else if (sts.found) cmd.status = ST_DUPLICATE;
            else if (!sts.have_free) cmd.status = ST_NO_SLOT;
            else begin
              cmd.create_init = 1'b1;
              state_nxt = S_ALLOC;
            end
          end
          KIND_DELETE: begin
            if (!sts.found) cmd.status = ST_NOT_FOUND;
            else begin
              cmd.map_read = 1'b1;
              state_nxt = S_FREE_A;
            end
          end
          KIND_TRANSLATE: begin
            if (!sts.found) cmd.status = ST_NOT_FOUND;
            else if (sts.idx_bad) cmd.status = ST_RANGE;
            else begin
              cmd.map_read = 1'b1;
              state_nxt = S_XLATE;
            end
          end
          KIND_NOP: ;
          default: ;
        endcase
      end
      S_ALLOC: begin
        if (sts.alloc_done) state_nxt = S_OUT;
        else cmd.alloc_step = 1'b1;
      end
      S_FREE_A: begin
        if (sts.free_done) begin
          cmd.delete_fin = 1'b1;
          state_nxt = S_OUT;
        end else state_nxt = S_FREE_B;
      end
      S_FREE_B: begin
        cmd.free_step = 1'b1;
        state_nxt = S_FREE_A;
      end
      S_XLATE: state_nxt = S_XWAIT;
      S_XWAIT: begin
        cmd.xlate_fin = 1'b1;
        state_nxt = S_OUT;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE && state_r != S_OUT) |-> !in_ready) else $error("accept while busy");
  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.search_step, cmd.alloc_step, cmd.free_step}) <= 1)
    else $error("overlapping steps");
endmodule

// File: rtl/inode_block_allocator.sv
// Inode table with free-block bitmap. One transaction in, one out.
// Each request runs a slot search and a decision, then for a create a bitmap
// scan (one block a cycle), for a delete a release of each of the file's
// blocks, or for a translate a block map read.
// One item at a time; the next is taken as the result is handed over.
// Synchronous active-low reset clears slots and bitmap (block 0 reserved).
module inode_block_allocator #(
  parameter int NUM_SLOTS = 16,
  parameter int NUM_BLOCKS = 128,
  parameter int BLOCKS_PER_FILE = 8
) (
  input logic clk,
  input logic rst_n,
  iba_if.sink   in_ch,
  iba_if.source out_ch
);
  import iba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  iba_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts(sts), .cmd(cmd)
  );

  iba_datapath #(
    .NumSlots(NUM_SLOTS), .NumBlocks(NUM_BLOCKS), .BlocksPerFile(BLOCKS_PER_FILE)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .req(in_ch.data), .cmd(cmd), .sts(sts), .rsp(out_ch.data)
  );
endmodule

// File: verif/iba_checker.sv
// Checker for the inode block allocator: watches both channels, keeps its own
// copy of the file table and bitmap, and compares every result transaction.
// Depends on iba_pkg.
`timescale 1ns / 100ps
module iba_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_ready,
  input  iba_pkg::req_t in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  iba_pkg::rsp_t out_data,
  output int            errors,
  output int            pending,
  output int            results_seen
);
  import iba_pkg::*;

  localparam int Slots = 16;
  localparam int Blocks = 128;
  localparam int PerFile = 8;

  logic             used_q [Slots];
  logic [NameW-1:0] name_q [Slots];
  int               size_q [Slots];
  int               map_q  [Slots*PerFile];
  logic             taken_q[Blocks];
  int               free_q;
  rsp_t             expected_rsps[$];

  function automatic void reset_model();
    for (int s = 0; s < Slots; s++) begin
      used_q[s] = 1'b0;
      name_q[s] = '0;
      size_q[s] = 0;
    end
    for (int i = 0; i < Slots*PerFile; i++) map_q[i] = 0;
    for (int b = 0; b < Blocks; b++) taken_q[b] = (b == 0);
    free_q = Blocks - 1;
  endfunction

  function automatic int lookup(logic [NameW-1:0] nm);
    for (int s = 0; s < Slots; s++)
      if (used_q[s] && name_q[s] == nm) return s;
    return -1;
  endfunction

  function automatic rsp_t apply_request(req_t rq);
    rsp_t r;
    int   slot;
    int   got;
    r = '0;
    r.status = ST_OK;
    unique case (rq.kind)
      KIND_CREATE: begin
        slot = -1;
        if (rq.block_count > PerFile) r.status = ST_BAD_SIZE;
        else if (free_q < rq.block_count) r.status = ST_NO_SPACE;
        else if (lookup(rq.file_name) >= 0) r.status = ST_DUPLICATE;
        else begin
          for (int s = Slots - 1; s >= 0; s--) if (!used_q[s]) slot = s;
          if (slot < 0) r.status = ST_NO_SLOT;
          else begin
            used_q[slot] = 1'b1;
            name_q[slot] = rq.file_name;
            size_q[slot] = rq.block_count;
            got = 0;
            for (int b = 1; b < Blocks; b++) begin
              if (got < rq.block_count && !taken_q[b]) begin
                taken_q[b] = 1'b1;
                map_q[slot*PerFile + got] = b;
                got++;
              end
            end
            free_q -= got;
          end
        end
      end
      KIND_DELETE: begin
        slot = lookup(rq.file_name);
        if (slot < 0) r.status = ST_NOT_FOUND;
        else begin
          for (int j = 0; j < size_q[slot]; j++) begin
            if (taken_q[map_q[slot*PerFile + j]]) begin
              taken_q[map_q[slot*PerFile + j]] = 1'b0;
              free_q++;
            end
          end
          used_q[slot] = 1'b0;
          size_q[slot] = 0;
        end
      end
      KIND_TRANSLATE: begin
        slot = lookup(rq.file_name);
        if (slot < 0) r.status = ST_NOT_FOUND;
        else if (rq.block_index >= size_q[slot]) r.status = ST_RANGE;
        else r.phys_block = PhysW'(map_q[slot*PerFile + rq.block_index]);
      end
      default: ;
    endcase
    r.free_count = FreeW'(free_q);
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    $display("checker: result %0d %s got %0d expected %0d", results_seen, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (!rst_n) begin
      reset_model();
      expected_rsps.delete();
      errors = 0;
      results_seen = 0;
    end else begin
      if (in_valid && in_ready) expected_rsps.push_back(apply_request(in_data));
      if (out_valid && out_ready) begin
        if (expected_rsps.size() == 0) begin
          report("unexpected transaction", 0, 0);
        end else begin
          want = expected_rsps.pop_front();
          if (out_data.status !== want.status)
            report("status", out_data.status, want.status);
          if (out_data.phys_block !== want.phys_block)
            report("phys_block", out_data.phys_block, want.phys_block);
          if (out_data.free_count !== want.free_count)
            report("free_count", out_data.free_count, want.free_count);
        end
        results_seen++;
      end
    end
    pending = expected_rsps.size();
  end

endmodule

// File: verif/tb.sv
// Top of the allocator testbench: clock, reset, request stimulus, result
// back-pressure and verdict. Depends on iba_pkg, iba_if, inode_block_allocator and iba_checker.
`timescale 1ns / 100ps
module tb;
  import iba_pkg::*;

  localparam int RandomItems = 1200;
  localparam int StallLimit = 3000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  req_t in_data = '0;
  logic out_ready = 1'b0;
  int   sink_wait = 0;
  logic quiet = 1'b0;
  int   errors, pending, results_seen;
  int   idle_cycles = 0;
  int   creates_sent = 0;

  logic [NameW-1:0] name_pool[24];

  iba_if #(.T(req_t)) in_ch ();
  iba_if #(.T(rsp_t)) out_ch ();

  assign in_ch.valid = in_valid;
  assign in_ch.data = in_data;
  assign out_ch.ready = out_ready;

  always #2 clk = ~clk;

  inode_block_allocator dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  iba_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .errors(errors), .pending(pending), .results_seen(results_seen)
  );

  function automatic int draw_wait();
    return quiet ? 0 : $urandom_range(0, 7);
  endfunction

  always @(posedge clk) begin
    int w;
    if (!rst_n) begin
      out_ready <= 1'b0;
      sink_wait <= 1;
    end else if (out_ready) begin
      if (out_ch.valid) begin
        w = draw_wait();
        if (w != 0) begin
          out_ready <= 1'b0;
          sink_wait <= w;
        end
      end
    end else begin
      if (sink_wait <= 1) out_ready <= 1'b1;
      sink_wait <= sink_wait - 1;
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("tb: watchdog expired with %0d results pending", pending);
      $display("tb: done, errors");
      $finish;
    end
  end

  task automatic send(logic [KindW-1:0] k, logic [NameW-1:0] nm,
                      logic [CountW-1:0] cnt, logic [IndexW-1:0] idx);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{kind: k, file_name: nm, block_count: cnt, block_index: idx};
    if (k == KIND_CREATE) creates_sent++;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  initial begin
    logic [KindW-1:0] k;
    logic [NameW-1:0] nm;
    logic [CountW-1:0] cnt;
    int pick;
    for (int i = 0; i < 24; i++) name_pool[i] = {$urandom, $urandom};
    name_pool[0] = '0;
    name_pool[1] = '1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(KIND_CREATE, name_pool[0], 4'd0, 3'd0);
    send(KIND_CREATE, name_pool[0], 4'd3, 3'd0);
    send(KIND_CREATE, name_pool[1], 4'd15, 3'd0);
    send(KIND_CREATE, name_pool[1], 4'd9, 3'd0);
    send(KIND_TRANSLATE, name_pool[0], 4'd0, 3'd0);
    send(KIND_DELETE, name_pool[2], 4'd0, 3'd0);
    send(KIND_TRANSLATE, name_pool[2], 4'd0, 3'd7);
    send(KIND_NOP, name_pool[1], 4'd15, 3'd7);
    send(KIND_CREATE, name_pool[1], 4'd8, 3'd0);
    send(KIND_TRANSLATE, name_pool[1], 4'd15, 3'd7);
    send(KIND_TRANSLATE, name_pool[1], 4'd0, 3'd0);
    for (int i = 2; i < 16; i++) send(KIND_CREATE, name_pool[i], 4'd8, 3'd0);
    send(KIND_CREATE, name_pool[16], 4'd8, 3'd0);
    send(KIND_CREATE, name_pool[16], 4'd0, 3'd0);

    for (int n = 0; n < RandomItems; n++) begin
      if (n % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 49) == 0) name_pool[$urandom_range(2, 23)] = {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      if (pick < 45) k = KIND_CREATE;
      else if (pick < 70) k = KIND_DELETE;
      else if (pick < 95) k = KIND_TRANSLATE;
      else k = KIND_NOP;
      nm = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} : name_pool[$urandom_range(0, 23)];
      cnt = ($urandom_range(0, 6) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
      send(k, nm, cnt, 3'($urandom_range(0, 7)));
    end
    in_valid <= 1'b0;
    quiet = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("tb: %0d results checked, %0d of them from creates issued", results_seen,
             creates_sent);
    $display("tb: table filled to capacity, then random mixes with random back-pressure");
    if (errors == 0 && pending == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/iba_pkg.sv
rtl/iba_if.sv
rtl/iba_ram.sv
rtl/iba_datapath.sv
rtl/iba_ctrl.sv
rtl/inode_block_allocator.sv
verif/iba_checker.sv
verif/tb.sv
